// File: design/ccf_pkg.sv
// ----------------------------------------------------------------------------
// Contour quad corner finder package
// Shared widths and register indexes for the corner finder and its channels.
// ----------------------------------------------------------------------------
package ccf_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIST_BITS  = 2 * COORD_BITS + 3;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_LEFT      = 3'd0,
        CFG_BOX_TOP       = 3'd1,
        CFG_BOX_RIGHT     = 3'd2,
        CFG_BOX_BOTTOM    = 3'd3,
        CFG_DIAGONAL_MODE = 3'd4
    } t_cfg_idx;

    typedef logic [COORD_BITS-1:0] t_coord;

endpackage

// File: design/ccf_point_if.sv
// ----------------------------------------------------------------------------
// Contour point channel
// Carries one contour point per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccf_point_if import ccf_pkg::*; ();

    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);

endinterface

// File: design/ccf_corner_if.sv
// ----------------------------------------------------------------------------
// Contour corner channel
// Carries the four corners of one contour per transaction.
// ----------------------------------------------------------------------------
interface ccf_corner_if import ccf_pkg::*; ();

    logic   valid;
    logic   ready;
    t_coord corner0_x;
    t_coord corner0_y;
    t_coord corner1_x;
    t_coord corner1_y;
    t_coord corner2_x;
    t_coord corner2_y;
    t_coord corner3_x;
    t_coord corner3_y;

    modport source (output valid,
                    output corner0_x, output corner0_y, output corner1_x, output corner1_y,
                    output corner2_x, output corner2_y, output corner3_x, output corner3_y,
                    input ready);
    modport sink   (input valid,
                    input corner0_x, input corner0_y, input corner1_x, input corner1_y,
                    input corner2_x, input corner2_y, input corner3_x, input corner3_y,
                    output ready);

endinterface

// File: design/contour_quad_corner_finder.sv
// The last point of a contour passes the stage registers s1 to s4; the corners are
// then registered into the output register and offered on the corner channel.
// Throughput: one point per cycle through a five-register pipeline; the pipeline
// holds only while a finished result waits and the next last point reaches the end.
// Reset (synchronous, active low) clears the configuration, the kept corners and
// all valid flags.
// ----------------------------------------------------------------------------
// Contour quad corner finder
// Sorts contour points into four regions of the bounding box and keeps, per
// region, the point farthest from a reference point; emits the four corners
// on the last point of the contour.
// ----------------------------------------------------------------------------
module contour_quad_corner_finder import ccf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    ccf_point_if.sink               i_pt,
    ccf_corner_if.source            o_crn
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB + 2;
    localparam int CW = 2 * CB + 3;
    localparam int SW = 2 * CB + 4;
    localparam int DW = DIST_BITS;

    t_coord r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic   r_diag;

    logic   w_adv;

    logic   r_s1_v, r_s1_last;
    t_coord r_s1_x, r_s1_y;

    logic                 r_s2_v, r_s2_last, r_s2_qhit;
    logic [1:0]           r_s2_qk;
    t_coord               r_s2_x, r_s2_y;
    logic signed [PW-1:0] r_s2_m1a, r_s2_m1b, r_s2_m2a, r_s2_m2b;

    logic                 r_s3_v, r_s3_last, r_s3_hit;
    logic [1:0]           r_s3_k;
    t_coord               r_s3_x, r_s3_y;
    logic signed [CB+1:0] r_s3_dx, r_s3_dy;

    logic          r_s4_v, r_s4_last, r_s4_hit;
    logic [1:0]    r_s4_k;
    t_coord        r_s4_x, r_s4_y;
    logic [DW-1:0] r_s4_d;

    t_coord        r_best_x [4];
    t_coord        r_best_y [4];
    logic [DW-1:0] r_best_d [4];

    logic   r_out_valid;
    t_coord r_out_x [4];
    t_coord r_out_y [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_right  <= '0;
            r_box_bottom <= '0;
            r_diag       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_LEFT:      r_box_left   <= i_cfg_data;
                CFG_BOX_TOP:       r_box_top    <= i_cfg_data;
                CFG_BOX_RIGHT:     r_box_right  <= i_cfg_data;
                CFG_BOX_BOTTOM:    r_box_bottom <= i_cfg_data;
                CFG_DIAGONAL_MODE: r_diag       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv = !(r_s4_v && r_s4_last && r_out_valid && !o_crn.ready);
    assign i_pt.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_x    <= i_pt.point_x;
            r_s1_y    <= i_pt.point_y;
            r_s1_last <= i_pt.last_point;
        end
    end

    logic [CB:0]          w_sum_lr, w_sum_tb;
    t_coord               w_hx, w_hy;
    logic signed [CB:0]   w_dxl, w_a1, w_c1, w_a2, w_c2, w_e;
    logic                 w_qhit;
    logic [1:0]           w_qk;

    assign w_sum_lr = {1'b0, r_box_left} + {1'b0, r_box_right};
    assign w_sum_tb = {1'b0, r_box_top} + {1'b0, r_box_bottom};
    assign w_hx     = w_sum_lr[CB:1];
    assign w_hy     = w_sum_tb[CB:1];

    assign w_dxl = $signed({1'b0, r_box_left}) - $signed({1'b0, r_box_right});
    assign w_a1  = $signed({1'b0, r_s1_y}) - $signed({1'b0, r_box_bottom});
    assign w_c1  = $signed({1'b0, r_box_top}) - $signed({1'b0, r_box_bottom});
    assign w_a2  = $signed({1'b0, r_s1_y}) - $signed({1'b0, r_box_top});
    assign w_c2  = $signed({1'b0, r_box_bottom}) - $signed({1'b0, r_box_top});
    assign w_e   = $signed({1'b0, r_s1_x}) - $signed({1'b0, r_box_right});

    always_comb begin
        w_qhit = 1'b1;
        w_qk   = 2'd0;
        if (r_s1_x < w_hx && r_s1_y <= w_hy) begin
            w_qk = 2'd0;
        end else if (r_s1_x >= w_hx && r_s1_y < w_hy) begin
            w_qk = 2'd1;
        end else if (r_s1_x > w_hx && r_s1_y >= w_hy) begin
            w_qk = 2'd2;
        end else if (r_s1_x <= w_hx && r_s1_y > w_hy) begin
            w_qk = 2'd3;
        end else begin
            w_qhit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_adv) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_last <= r_s1_last;
            r_s2_qhit <= w_qhit;
            r_s2_qk   <= w_qk;
            r_s2_m1a  <= PW'(w_a1) * PW'(w_dxl);
            r_s2_m1b  <= PW'(w_c1) * PW'(w_e);
            r_s2_m2a  <= PW'(w_a2) * PW'(w_dxl);
            r_s2_m2b  <= PW'(w_c2) * PW'(w_e);
        end
    end

    logic signed [CW-1:0] w_cr1, w_cr2;
    logic                 w_neg_dir, w_p1_pos, w_p1_neg, w_p2_pos, w_p2_neg;
    logic                 w_hit;
    logic [1:0]           w_k;
    logic [CB:0]          w_rx, w_ry;

    assign w_cr1 = CW'(r_s2_m1a) - CW'(r_s2_m1b);
    assign w_cr2 = CW'(r_s2_m2a) - CW'(r_s2_m2b);
    assign w_neg_dir = w_dxl[CB];

    assign w_p1_pos = w_neg_dir ? (w_cr1 < 0) : (w_cr1 > 0);
    assign w_p1_neg = w_neg_dir ? (w_cr1 > 0) : (w_cr1 < 0);
    assign w_p2_pos = w_neg_dir ? (w_cr2 < 0) : (w_cr2 > 0);
    assign w_p2_neg = w_neg_dir ? (w_cr2 > 0) : (w_cr2 < 0);

    always_comb begin
        w_hit = 1'b0;
        w_k   = 2'd0;
        w_rx  = '0;
        w_ry  = '0;
        if (r_diag) begin
            if (w_dxl != 0) begin
                w_hit = 1'b1;
                if (!w_p1_neg && w_p2_pos) begin
                    w_k  = 2'd1;
                    w_rx = w_sum_lr;
                    w_ry = {r_box_top, 1'b0};
                end else if (w_p1_pos && !w_p2_pos) begin
                    w_k  = 2'd2;
                    w_rx = {r_box_right, 1'b0};
                    w_ry = w_sum_tb;
                end else if (!w_p1_pos && w_p2_neg) begin
                    w_k  = 2'd3;
                    w_rx = w_sum_lr;
                    w_ry = {r_box_bottom, 1'b0};
                end else if (w_p1_neg && !w_p2_neg) begin
                    w_k  = 2'd0;
                    w_rx = {r_box_left, 1'b0};
                    w_ry = w_sum_tb;
                end else begin
                    w_hit = 1'b0;
                end
            end
        end else begin
            w_hit = r_s2_qhit;
            w_k   = r_s2_qk;
            case (r_s2_qk)
                2'd0: begin
                    w_rx = {r_box_right, 1'b0};
                    w_ry = {r_box_bottom, 1'b0};
                end
                2'd1: begin
                    w_rx = {r_box_left, 1'b0};
                    w_ry = {r_box_bottom, 1'b0};
                end
                2'd2: begin
                    w_rx = {r_box_left, 1'b0};
                    w_ry = {r_box_top, 1'b0};
                end
                default: begin
                    w_rx = {r_box_right, 1'b0};
                    w_ry = {r_box_top, 1'b0};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_adv) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
            r_s3_last <= r_s2_last;
            r_s3_hit  <= w_hit;
            r_s3_k    <= w_k;
            r_s3_dx   <= $signed({1'b0, r_s2_x, 1'b0}) - $signed({1'b0, w_rx});
            r_s3_dy   <= $signed({1'b0, r_s2_y, 1'b0}) - $signed({1'b0, w_ry});
        end
    end

    logic signed [SW-1:0] w_sqx, w_sqy;

    assign w_sqx = SW'(r_s3_dx) * SW'(r_s3_dx);
    assign w_sqy = SW'(r_s3_dy) * SW'(r_s3_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_adv) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_x    <= r_s3_x;
            r_s4_y    <= r_s3_y;
            r_s4_last <= r_s3_last;
            r_s4_hit  <= r_s3_hit;
            r_s4_k    <= r_s3_k;
            r_s4_d    <= DW'(w_sqx) + DW'(w_sqy);
        end
    end

    logic [3:0] w_upd;
    logic       w_emit;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_upd[j] = r_s4_v && r_s4_hit && (r_s4_k == 2'(j)) && (r_s4_d > r_best_d[j]);
        end
    end

    assign w_emit = w_adv && r_s4_v && r_s4_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_best_x[j] <= '0;
                r_best_y[j] <= '0;
                r_best_d[j] <= '0;
            end
        end else if (w_adv && r_s4_v) begin
            for (int j = 0; j < 4; j++) begin
                if (r_s4_last) begin
                    r_best_x[j] <= '0;
                    r_best_y[j] <= '0;
                    r_best_d[j] <= '0;
                end else if (w_upd[j]) begin
                    r_best_x[j] <= r_s4_x;
                    r_best_y[j] <= r_s4_y;
                    r_best_d[j] <= r_s4_d;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_crn.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            for (int j = 0; j < 4; j++) begin
                r_out_x[j] <= w_upd[j] ? r_s4_x : r_best_x[j];
                r_out_y[j] <= w_upd[j] ? r_s4_y : r_best_y[j];
            end
        end
    end

    assign o_crn.valid     = r_out_valid;
    assign o_crn.corner0_x = r_out_x[0];
    assign o_crn.corner0_y = r_out_y[0];
    assign o_crn.corner1_x = r_out_x[1];
    assign o_crn.corner1_y = r_out_y[1];
    assign o_crn.corner2_x = r_out_x[2];
    assign o_crn.corner2_y = r_out_y[2];
    assign o_crn.corner3_x = r_out_x[3];
    assign o_crn.corner3_y = r_out_y[3];

`ifndef SYNTHESIS
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("finished contour did not raise the output transaction");

    a_emit_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_best_d[0] == '0 && r_best_d[1] == '0 &&
                    r_best_d[2] == '0 && r_best_d[3] == '0))
        else $error("kept corners not cleared after a contour");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> (r_out_valid && !o_crn.ready && r_s4_v && r_s4_last))
        else $error("pipeline held without a blocked result");

    a_dist_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_emit |=> (r_best_d[0] >= $past(r_best_d[0]) &&
                     r_best_d[2] >= $past(r_best_d[2])))
        else $error("kept distance decreased within a contour");
`endif

endmodule
